>>> rtl/hsir_pkg.sv
`timescale 1ns / 1ps
package hsir_pkg;

  localparam int unsigned QuarterTicksW = 16;
  localparam int unsigned MsTicksW = 20;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgIndexW = 3;

  localparam logic [CfgIndexW-1:0] CFG_QUARTER_TICKS = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_MS_TICKS = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_DEVICE_ADDRESS = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_POLL_LIMIT = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_TRIGGER_WAIT = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_POLL_INTERVAL = 3'd5;

  localparam logic [15:0] RstQuarterTicks = 16'd500;
  localparam logic [19:0] RstMsTicks = 20'd100000;
  localparam logic [6:0] RstDeviceAddress = 7'd56;
  localparam logic [7:0] RstPollLimit = 8'd100;
  localparam logic [7:0] RstTriggerWait = 8'd80;
  localparam logic [7:0] RstPollInterval = 8'd10;

  localparam logic [7:0] PowerWaitMs = 8'd140;
  localparam logic [7:0] ResetWaitMs = 8'd20;
  localparam logic [7:0] CalWaitMs = 8'd10;

  localparam logic [2:0] ERR_OK = 3'd0;
  localparam logic [2:0] ERR_ADDR_WR = 3'd1;
  localparam logic [2:0] ERR_DATA = 3'd2;
  localparam logic [2:0] ERR_ADDR_RD = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT = 3'd4;
  localparam logic [2:0] ERR_STATUS = 3'd5;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_CAL   = 2'd1,
    CMD_TRIG  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [0:0] scl_level;
    logic [0:0] sda_level;
    logic [0:0] measure_request;
  } in_item_t;

  typedef struct packed {
    logic [0:0] sda_pull_low;
    logic [0:0] scl_pull_low;
    logic [0:0] ready_res;
    logic [0:0] done_res;
    logic [13:0] humidity_centi;
    logic signed [14:0] temperature_centi;
    logic [2:0] error_code;
    logic [0:0] calibrated;
    logic [7:0] status_byte;
  } out_item_t;

  function automatic logic [7:0] cmd_byte(input cmd_t cmd, input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (cmd)
      CMD_RESET: b = (idx == 2'd0) ? 8'hBA : 8'h00;
      CMD_CAL: begin
        case (idx)
          2'd0: b = 8'hE1;
          2'd1: b = 8'h08;
          default: b = 8'h00;
        endcase
      end
      CMD_TRIG: begin
        case (idx)
          2'd0: b = 8'hAC;
          2'd1: b = 8'h33;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/hsir_if.sv
`timescale 1ns / 1ps
interface hsir_in_if;
  logic valid;
  logic ready;
  hsir_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hsir_out_if;
  logic valid;
  logic ready;
  hsir_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/humidity_sensor_i2c_reader_core.sv
`timescale 1ns / 1ps
// Bit-banged I2C reader for a humidity/temperature sensor. Every request on
// the input channel is one clock tick carrying the sampled SCL and SDA levels
// and a measure request; it yields exactly one result request with the line
// drives, status and the latest humidity and temperature readings. One
// request is taken every cycle unless stalled: the sequencer state register
// is updated at the acceptance edge and the result is held in a single output
// register, so input ready follows whether that register is free or drained.
// After reset the set-up sequence (power-up wait, soft reset, calibrate)
// runs on its own as ticks arrive; bus timing is counted in ticks.
module humidity_sensor_i2c_reader_core (
  input  logic clk,
  input  logic rst,
  hsir_in_if.sink in_ch,
  hsir_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [hsir_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [hsir_pkg::CfgDataW-1:0] cfg_data
);

  typedef enum logic [4:0] {
    P_POWER_WAIT, P_RESET_CMD, P_RESET_WAIT, P_STATUS_READ, P_POLL1_READ,
    P_POLL1_WAIT, P_CAL_CMD, P_CAL_WAIT, P_POLL2_READ, P_POLL2_WAIT,
    P_FINAL_READ, P_IDLE, P_TRIG_CMD, P_TRIG_WAIT, P_POLL3_READ,
    P_POLL3_WAIT, P_DATA_READ
  } phase_t;

  typedef enum logic [1:0] {SEG_START, SEG_WBIT, SEG_RBIT, SEG_STOP} seg_t;

  typedef struct packed {
    phase_t phase;
    logic [3:0] bit_count;
    logic [2:0] byte_count;
    logic [7:0] shift_byte;
    logic [15:0] step_timer;
    logic [19:0] milli_timer;
    logic [7:0] wait_left_ms;
    logic [7:0] polls_left;
    logic [19:0] humidity_raw;
    logic [19:0] temperature_raw;
    logic [7:0] last_status;
    logic calibrated_flag;
    logic [2:0] last_error;
    logic bus_busy;
    logic ack_seen;
    logic addr_stage;
    seg_t seg;
    logic [1:0] sub;
    logic txn_read;
    logic [2:0] txn_len;
    hsir_pkg::cmd_t txn_cmd;
    logic [2:0] txn_code;
    logic drv_sda;
    logic drv_scl;
    logic [7:0] rx0;
    logic [7:0] rx1;
    logic [7:0] rx2;
    logic [7:0] rx3;
    logic [7:0] rx4;
    logic [7:0] rx5;
  } st_t;

  logic [15:0] quarter_ticks;
  logic [19:0] ms_ticks;
  logic [6:0] device_address;
  logic [7:0] poll_limit;
  logic [7:0] trigger_wait_ms;
  logic [7:0] poll_interval_ms;

  st_t st, st_next;
  logic done_next;
  logic ready_now;
  logic accept;
  logic out_valid;
  hsir_pkg::out_item_t out_data;

  logic [33:0] hum_prod;
  logic [34:0] tmp_prod;
  logic [13:0] hum_centi;
  logic [14:0] tmp_centi;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_ticks <= hsir_pkg::RstQuarterTicks;
      ms_ticks <= hsir_pkg::RstMsTicks;
      device_address <= hsir_pkg::RstDeviceAddress;
      poll_limit <= hsir_pkg::RstPollLimit;
      trigger_wait_ms <= hsir_pkg::RstTriggerWait;
      poll_interval_ms <= hsir_pkg::RstPollInterval;
    end else if (cfg_we) begin
      case (cfg_index)
        hsir_pkg::CFG_QUARTER_TICKS: quarter_ticks <= cfg_data[15:0];
        hsir_pkg::CFG_MS_TICKS: ms_ticks <= cfg_data[19:0];
        hsir_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        hsir_pkg::CFG_POLL_LIMIT: poll_limit <= cfg_data[7:0];
        hsir_pkg::CFG_TRIGGER_WAIT: trigger_wait_ms <= cfg_data[7:0];
        hsir_pkg::CFG_POLL_INTERVAL: poll_interval_ms <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  function automatic st_t set_drive(input st_t s);
    st_t r;
    r = s;
    case (s.seg)
      SEG_START: begin
        r.drv_sda = (s.sub >= 2'd1);
        r.drv_scl = (s.sub >= 2'd2);
      end
      SEG_WBIT: begin
        r.drv_sda = (s.bit_count < 4'd8) ? ~s.shift_byte[3'd7 - s.bit_count[2:0]] : 1'b0;
        r.drv_scl = (s.sub != 2'd1);
      end
      SEG_RBIT: begin
        r.drv_sda = (s.bit_count == 4'd8) && ({1'b0, s.byte_count} + 4'd1 < {1'b0, s.txn_len});
        r.drv_scl = (s.sub != 2'd1);
      end
      default: begin
        r.drv_sda = (s.sub <= 2'd1);
        r.drv_scl = (s.sub == 2'd0);
      end
    endcase
    return r;
  endfunction

  function automatic st_t begin_txn(input st_t s, input logic rd, input logic [2:0] len,
                                    input hsir_pkg::cmd_t cmd);
    st_t r;
    r = s;
    r.bus_busy = 1'b1;
    r.txn_read = rd;
    r.txn_len = len;
    r.txn_cmd = cmd;
    r.txn_code = hsir_pkg::ERR_OK;
    r.seg = SEG_START;
    r.sub = 2'd0;
    r.step_timer = '0;
    return set_drive(r);
  endfunction

  function automatic st_t start_wait(input st_t s, input logic [7:0] ms);
    st_t r;
    r = s;
    r.wait_left_ms = ms;
    r.milli_timer = '0;
    return r;
  endfunction

  function automatic st_t goto_phase(input st_t s, input phase_t p);
    st_t r;
    r = s;
    r.phase = p;
    case (p)
      P_POWER_WAIT: r = start_wait(r, hsir_pkg::PowerWaitMs);
      P_RESET_CMD: r = begin_txn(r, 1'b0, 3'd1, hsir_pkg::CMD_RESET);
      P_RESET_WAIT: r = start_wait(r, hsir_pkg::ResetWaitMs);
      P_STATUS_READ, P_POLL1_READ, P_POLL2_READ, P_FINAL_READ, P_POLL3_READ:
        r = begin_txn(r, 1'b1, 3'd1, hsir_pkg::CMD_RESET);
      P_POLL1_WAIT, P_POLL2_WAIT, P_POLL3_WAIT: r = start_wait(r, poll_interval_ms);
      P_CAL_CMD: r = begin_txn(r, 1'b0, 3'd3, hsir_pkg::CMD_CAL);
      P_CAL_WAIT: r = start_wait(r, hsir_pkg::CalWaitMs);
      P_TRIG_CMD: r = begin_txn(r, 1'b0, 3'd3, hsir_pkg::CMD_TRIG);
      P_TRIG_WAIT: r = start_wait(r, trigger_wait_ms);
      P_DATA_READ: r = begin_txn(r, 1'b1, 3'd7, hsir_pkg::CMD_RESET);
      default: r.phase = P_IDLE;
    endcase
    return r;
  endfunction

  function automatic st_t reset_state();
    st_t r;
    r = '0;
    r.seg = SEG_STOP;
    return goto_phase(r, P_POWER_WAIT);
  endfunction

  always_comb begin
    st_t s;
    logic ok;
    logic busy;
    logic sda;
    logic [7:0] rxb;
    logic [2:0] bc1;
    s = st;
    done_next = 1'b0;
    ok = 1'b0;
    busy = 1'b0;
    rxb = 8'h00;
    bc1 = 3'd0;
    sda = in_ch.data.sda_level;
    if (st.phase == P_IDLE) begin
      if (in_ch.data.measure_request) begin
        s.last_error = hsir_pkg::ERR_OK;
        s = goto_phase(s, P_TRIG_CMD);
      end
    end else if (st.bus_busy) begin
      if (!(st.drv_scl == 1'b0 && in_ch.data.scl_level == 1'b0)) begin
        if ({16'd0, st.step_timer} + 32'd1 >= {16'd0, quarter_ticks}) begin
          s.step_timer = '0;
          case (st.seg)
            SEG_START: begin
              if (st.sub < 2'd2) s.sub = st.sub + 2'd1;
              else begin
                s.seg = SEG_WBIT;
                s.sub = 2'd0;
                s.bit_count = '0;
                s.byte_count = '0;
                s.addr_stage = 1'b1;
                s.shift_byte = {device_address, st.txn_read};
              end
              s = set_drive(s);
            end
            SEG_WBIT: begin
              if (st.sub == 2'd1 && st.bit_count == 4'd8) s.ack_seen = !sda;
              if (st.sub < 2'd2) s.sub = st.sub + 2'd1;
              else begin
                s.sub = 2'd0;
                if (st.bit_count < 4'd8) s.bit_count = st.bit_count + 4'd1;
                else if (!st.ack_seen) begin
                  s.txn_code = st.addr_stage ?
                      (st.txn_read ? hsir_pkg::ERR_ADDR_RD : hsir_pkg::ERR_ADDR_WR) :
                      hsir_pkg::ERR_DATA;
                  s.seg = SEG_STOP;
                end else if (st.addr_stage && st.txn_read) begin
                  s.addr_stage = 1'b0;
                  s.seg = SEG_RBIT;
                  s.bit_count = '0;
                  s.byte_count = '0;
                  s.shift_byte = '0;
                end else begin
                  s.addr_stage = 1'b0;
                  if (st.byte_count < st.txn_len) begin
                    s.shift_byte = hsir_pkg::cmd_byte(st.txn_cmd, st.byte_count[1:0]);
                    s.byte_count = st.byte_count + 3'd1;
                    s.bit_count = '0;
                  end else s.seg = SEG_STOP;
                end
              end
              s = set_drive(s);
            end
            SEG_RBIT: begin
              if (st.sub == 2'd1 && st.bit_count < 4'd8)
                s.shift_byte = {st.shift_byte[6:0], sda};
              if (st.sub < 2'd2) s.sub = st.sub + 2'd1;
              else begin
                s.sub = 2'd0;
                if (st.bit_count < 4'd8) s.bit_count = st.bit_count + 4'd1;
                else begin
                  case (st.byte_count)
                    3'd0: s.rx0 = st.shift_byte;
                    3'd1: s.rx1 = st.shift_byte;
                    3'd2: s.rx2 = st.shift_byte;
                    3'd3: s.rx3 = st.shift_byte;
                    3'd4: s.rx4 = st.shift_byte;
                    3'd5: s.rx5 = st.shift_byte;
                    default: ;
                  endcase
                  bc1 = st.byte_count + 3'd1;
                  s.byte_count = bc1;
                  if (bc1 >= st.txn_len || bc1 == 3'd0) s.seg = SEG_STOP;
                  else begin
                    s.bit_count = '0;
                    s.shift_byte = '0;
                  end
                end
              end
              s = set_drive(s);
            end
            default: begin
              if (st.sub < 2'd2) begin
                s.sub = st.sub + 2'd1;
                s = set_drive(s);
              end else begin
                s.bus_busy = 1'b0;
                s.drv_sda = 1'b0;
                s.drv_scl = 1'b0;
                ok = (st.txn_code == hsir_pkg::ERR_OK);
                rxb = st.rx0;
                case (st.phase)
                  P_RESET_CMD, P_CAL_CMD: begin
                    if (ok) s = goto_phase(s, (st.phase == P_RESET_CMD) ? P_RESET_WAIT
                                                                      : P_CAL_WAIT);
                    else begin
                      s.calibrated_flag = 1'b0;
                      s.last_error = st.txn_code;
                      done_next = 1'b1;
                      s = goto_phase(s, P_IDLE);
                    end
                  end
                  P_STATUS_READ: begin
                    if (ok) begin
                      s.last_status = rxb;
                      s.polls_left = poll_limit;
                      s = goto_phase(s, P_POLL1_READ);
                    end else begin
                      s.calibrated_flag = 1'b0;
                      s.last_error = hsir_pkg::ERR_STATUS;
                      done_next = 1'b1;
                      s = goto_phase(s, P_IDLE);
                    end
                  end
                  P_POLL1_READ, P_POLL2_READ, P_POLL3_READ: begin
                    busy = !ok || rxb[7];
                    if (ok) s.last_status = rxb;
                    if (!busy) begin
                      s = goto_phase(s, (st.phase == P_POLL1_READ) ? P_CAL_CMD :
                                        (st.phase == P_POLL2_READ) ? P_FINAL_READ :
                                        P_DATA_READ);
                    end else if (st.polls_left != 8'd0) begin
                      s.polls_left = st.polls_left - 8'd1;
                      s = goto_phase(s, (st.phase == P_POLL1_READ) ? P_POLL1_WAIT :
                                        (st.phase == P_POLL2_READ) ? P_POLL2_WAIT :
                                        P_POLL3_WAIT);
                    end else if (st.phase == P_POLL3_READ) begin
                      s.last_error = hsir_pkg::ERR_TIMEOUT;
                      done_next = 1'b1;
                      s = goto_phase(s, P_IDLE);
                    end else begin
                      s = goto_phase(s, (st.phase == P_POLL1_READ) ? P_CAL_CMD
                                                                   : P_FINAL_READ);
                    end
                  end
                  P_FINAL_READ: begin
                    if (ok) begin
                      s.last_status = rxb;
                      s.calibrated_flag = rxb[3];
                      s.last_error = hsir_pkg::ERR_OK;
                    end else begin
                      s.calibrated_flag = 1'b0;
                      s.last_error = hsir_pkg::ERR_STATUS;
                    end
                    done_next = 1'b1;
                    s = goto_phase(s, P_IDLE);
                  end
                  P_TRIG_CMD: begin
                    if (ok) s = goto_phase(s, P_TRIG_WAIT);
                    else begin
                      s.last_error = st.txn_code;
                      done_next = 1'b1;
                      s = goto_phase(s, P_IDLE);
                    end
                  end
                  P_DATA_READ: begin
                    if (ok) begin
                      s.last_status = rxb;
                      s.humidity_raw = {st.rx1, st.rx2, st.rx3[7:4]};
                      s.temperature_raw = {st.rx3[3:0], st.rx4, st.rx5};
                      s.last_error = hsir_pkg::ERR_OK;
                    end else s.last_error = hsir_pkg::ERR_ADDR_RD;
                    done_next = 1'b1;
                    s = goto_phase(s, P_IDLE);
                  end
                  default: s = goto_phase(s, P_IDLE);
                endcase
              end
            end
          endcase
        end else s.step_timer = st.step_timer + 16'd1;
      end
    end else begin
      if (st.wait_left_ms == 8'd0) begin
        case (st.phase)
          P_POWER_WAIT: s = goto_phase(s, P_RESET_CMD);
          P_RESET_WAIT: s = goto_phase(s, P_STATUS_READ);
          P_CAL_WAIT: begin
            s.polls_left = poll_limit;
            s = goto_phase(s, P_POLL2_READ);
          end
          P_TRIG_WAIT: begin
            s.polls_left = poll_limit;
            s = goto_phase(s, P_POLL3_READ);
          end
          P_POLL1_WAIT: s = goto_phase(s, P_POLL1_READ);
          P_POLL2_WAIT: s = goto_phase(s, P_POLL2_READ);
          P_POLL3_WAIT: s = goto_phase(s, P_POLL3_READ);
          default: s = goto_phase(s, P_IDLE);
        endcase
      end else if ({1'b0, st.milli_timer} + 21'd1 >= {1'b0, ms_ticks}) begin
        s.milli_timer = '0;
        s.wait_left_ms = st.wait_left_ms - 8'd1;
      end else s.milli_timer = st.milli_timer + 20'd1;
    end
    st_next = s;
  end

  assign ready_now = (st.phase == P_IDLE);
  assign hum_prod = {14'd0, st_next.humidity_raw} * 34'd10000;
  assign tmp_prod = {15'd0, st_next.temperature_raw} * 35'd20000;
  assign hum_centi = hum_prod[33:20];
  assign tmp_centi = tmp_prod[34:20] - 15'd5000;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= reset_state();
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) out_valid <= 1'b0;
    end
    if (accept) begin
      out_data.sda_pull_low <= st_next.drv_sda;
      out_data.scl_pull_low <= st_next.drv_scl;
      out_data.ready_res <= ready_now;
      out_data.done_res <= done_next;
      out_data.humidity_centi <= hum_centi;
      out_data.temperature_centi <= tmp_centi;
      out_data.error_code <= st_next.last_error;
      out_data.calibrated <= st_next.calibrated_flag;
      out_data.status_byte <= st_next.last_status;
    end
  end

endmodule
